// ===== hw/rtl/nkws_pkg.sv =====
// Types, keyword ROM and codepoint helpers for the normalized UTF-8 keyword scanner.
// Used by nkws_decoder, nkws_cell and normalized_utf8_keyword_scanner_unit.
// No dependencies.
package nkws_pkg;

    localparam int KW_COUNT   = 50;
    localparam int KW_MAX_LEN = 4;
    localparam int KW_LEN_W   = $clog2(KW_MAX_LEN + 1);
    localparam int CP_W       = 21;

    typedef logic [CP_W-1:0]      cp_t;
    typedef logic [KW_LEN_W-1:0]  kw_len_t;
    typedef logic [KW_COUNT-1:0]  kw_vec_t;

    typedef struct packed {
        logic a_valid;
        cp_t  a_cp;
        logic b_valid;
        cp_t  b_cp;
    } cp_pair_t;

    localparam logic [2:0] FOLLOW_BAD = 3'd4;

    localparam kw_len_t KW_LEN [KW_COUNT] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2,
        3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4,
        3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    localparam cp_t KW_CP [KW_COUNT][KW_MAX_LEN] = '{
        '{21'h65E5, 21'h7ED3, 21'h0, 21'h0},
        '{21'h65E5, 21'h8D5A, 21'h0, 21'h0},
        '{21'h6708, 21'h5165, 21'h0, 21'h0},
        '{21'h5237, 21'h5355, 21'h0, 21'h0},
        '{21'h517C, 21'h804C, 21'h0, 21'h0},
        '{21'h517C, 21'h804C, 21'h0, 21'h0},
        '{21'h7F51, 21'h8D37, 21'h0, 21'h0},
        '{21'h8D37, 21'h6B3E, 21'h0, 21'h0},
        '{21'h8D37, 21'h6B3E, 21'h0, 21'h0},
        '{21'h535A, 21'h5F69, 21'h0, 21'h0},
        '{21'h8D4C, 21'h535A, 21'h0, 21'h0},
        '{21'h8D4C, 21'h535A, 21'h0, 21'h0},
        '{21'h4EE3, 21'h5F00, 21'h0, 21'h0},
        '{21'h53D1, 21'h7968, 21'h0, 21'h0},
        '{21'h5F15, 21'h6D41, 21'h0, 21'h0},
        '{21'h4EE3, 21'h7406, 21'h0, 21'h0},
        '{21'h9AD8, 21'h85AA, 21'h0, 21'h0},
        '{21'h8F7B, 21'h677E, 21'h8D5A, 21'h0},
        '{21'h5728, 21'h5BB6, 21'h505A, 21'h0},
        '{21'h5957, 21'h73B0, 21'h0, 21'h0},
        '{21'h6D17, 21'h94B1, 21'h0, 21'h0},
        '{21'h8FD4, 21'h5229, 21'h0, 21'h0},
        '{21'h6295, 21'h8D44, 21'h7406, 21'h8D22},
        '{21'h68CB, 21'h724C, 21'h0, 21'h0},
        '{21'h529E, 21'h8BC1, 21'h0, 21'h0},
        '{21'h9AD8, 21'h4EFF, 21'h0, 21'h0},
        '{21'h7EA6, 21'h70AE, 21'h0, 21'h0},
        '{21'h770B, 21'h7247, 21'h0, 21'h0},
        '{21'h75, 21'h73, 21'h64, 21'h74},
        '{21'h75, 21'h73, 21'h64, 21'h74},
        '{21'h7A7A, 21'h6295, 21'h0, 21'h0},
        '{21'h64B8, 21'h6BDB, 21'h0, 21'h0},
        '{21'h8585, 21'h7F8A, 21'h6BDB, 21'h0},
        '{21'h63A5, 21'h7801, 21'h0, 21'h0},
        '{21'h5361, 21'h5546, 21'h0, 21'h0},
        '{21'h6599, 21'h5B50, 21'h0, 21'h0},
        '{21'h62C5, 21'h4FDD, 21'h0, 21'h0},
        '{21'h4EE3, 21'h5145, 21'h0, 21'h0},
        '{21'h4E0A, 21'h5206, 21'h0, 21'h0},
        '{21'h4E0B, 21'h5206, 21'h0, 21'h0},
        '{21'h5E26, 21'h5355, 21'h0, 21'h0},
        '{21'h6740, 21'h732A, 21'h76D8, 21'h0},
        '{21'h8D5A, 21'h0, 21'h0, 21'h0},
        '{21'h8D4C, 21'h0, 21'h0, 21'h0},
        '{21'h8D37, 21'h0, 21'h0, 21'h0},
        '{21'h5237, 21'h0, 21'h0, 21'h0},
        '{21'h5AD6, 21'h0, 21'h0, 21'h0},
        '{21'h70AE, 21'h0, 21'h0, 21'h0},
        '{21'h6DEB, 21'h0, 21'h0, 21'h0},
        '{21'h6BD2, 21'h0, 21'h0, 21'h0}
    };

    function automatic logic [2:0] follow_count(input logic [7:0] b);
        logic [2:0] f;
        if (b < 8'h80) f = 3'd0;
        else if ((b & 8'hE0) == 8'hC0) f = 3'd1;
        else if ((b & 8'hF0) == 8'hE0) f = 3'd2;
        else if ((b & 8'hF8) == 8'hF0) f = 3'd3;
        else f = FOLLOW_BAD;
        return f;
    endfunction

    function automatic logic is_dropped(input cp_t c);
        return c inside {21'h00AD, 21'h034F, 21'h061C, 21'h180E, 21'hFEFF,
                         [21'h200B:21'h200F], [21'h202A:21'h202E],
                         [21'h2060:21'h206F], [21'hFE00:21'hFE0F],
                         [21'hE0100:21'hE01EF], [21'h0300:21'h036F]};
    endfunction

    function automatic cp_t fold_cp(input cp_t raw);
        cp_t c;
        cp_t r;
        c = raw;
        if (c inside {[21'hFF01:21'hFF5E]}) c = c - 21'hFEE0;
        if (c inside {[21'h41:21'h5A]}) begin
            r = c + 21'd32;
        end
        else begin
            case (c)
                21'h8CFA: r = 21'h8D5A;
                21'h8CED: r = 21'h8D4C;
                21'h8CB8: r = 21'h8D37;
                21'h55AE: r = 21'h5355;
                21'h7DB2: r = 21'h7F51;
                21'h8B49: r = 21'h8BC1;
                21'h767C: r = 21'h53D1;
                21'h8077: r = 21'h804C;
                21'h9322: r = 21'h94B1;
                21'h5E63: r = 21'h5E01;
                21'h7121: r = 21'h65E0;
                default:  r = c;
            endcase
        end
        return r;
    endfunction

    function automatic kw_vec_t len_mask(input int pos);
        kw_vec_t m;
        for (int k = 0; k < KW_COUNT; k++) begin
            m[k] = (int'(KW_LEN[k]) == pos + 1);
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/normalized_utf8_keyword_scanner_unit.sv =====
// Top level of the normalized UTF-8 keyword scanner: decoder, row of match
// cells and result register. Depends on nkws_pkg, nkws_decoder, nkws_cell.
//
//   channel  | signals                               | beat
//   ---------+---------------------------------------+----------------------------
//   text     | text_valid text_ready text_byte       | one byte, last_byte ends text
//            | last_byte                             |
//   result   | result_valid result_ready             | one flag per text
//            | keyword_found                         |
//
// One byte per cycle while text_ready is high; decode, fold and the per-cell
// keyword compare finish in the cycle the beat is accepted. The result shows in
// the cycle after the last byte and holds until taken; text_ready stays high
// while the result register is empty or being taken, and drops while a result
// waits untaken. Reset clears decoder, cells and result_valid, not keyword_found.
module normalized_utf8_keyword_scanner_unit
    import nkws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       keyword_found
);

    logic     accept;
    logic     clear;
    cp_pair_t cps;
    kw_vec_t  cell_state [KW_MAX_LEN-1];
    kw_vec_t  cell_step  [KW_MAX_LEN-1];
    logic [KW_MAX_LEN-1:0] cell_hit;
    logic     any_hit;
    logic     found_reg, found_next;
    logic     result_valid_reg, result_valid_next;
    logic     keyword_found_reg;

    assign text_ready = !result_valid_reg || result_ready;
    assign accept     = text_valid && text_ready;
    assign clear      = accept && last_byte;

    nkws_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .cps       (cps)
    );

    for (genvar p = 0; p < KW_MAX_LEN; p++) begin : g_cell
        kw_vec_t left_state, left_step;
        if (p == 0) begin : g_head
            assign left_state = '1;
            assign left_step  = '1;
        end
        else begin : g_body
            assign left_state = cell_state[p-1];
            assign left_step  = cell_step[p-1];
        end
        if (p == KW_MAX_LEN - 1) begin : g_tail
            nkws_cell #(.POS(p)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (accept),
                .clear      (clear),
                .cps        (cps),
                .left_state (left_state),
                .left_step  (left_step),
                .state      (),
                .step       (),
                .hit        (cell_hit[p])
            );
        end
        else begin : g_mid
            nkws_cell #(.POS(p)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (accept),
                .clear      (clear),
                .cps        (cps),
                .left_state (left_state),
                .left_step  (left_step),
                .state      (cell_state[p]),
                .step       (cell_step[p]),
                .hit        (cell_hit[p])
            );
        end
    end

    always_comb
    begin
        any_hit    = |cell_hit;
        found_next = found_reg || any_hit;
        if (clear) begin
            result_valid_next = 1'b1;
        end
        else if (result_ready) begin
            result_valid_next = 1'b0;
        end
        else begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else begin
            result_valid_reg <= result_valid_next;
            if (accept) begin
                found_reg <= clear ? 1'b0 : found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear) keyword_found_reg <= found_next;
    end

    assign result_valid  = result_valid_reg;
    assign keyword_found = keyword_found_reg;

    a_found_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> !found_reg)
        else $error("found flag carried across texts");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !clear |=> found_reg)
        else $error("found flag dropped inside a text");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(clear))
        else $error("result raised without a final byte");

    a_hit_reported: assert property (@(posedge clk) disable iff (!rst_n)
        clear && any_hit |=> result_valid_reg && keyword_found_reg)
        else $error("hit on final byte not reported");

endmodule

// ===== hw/rtl/nkws_decoder.sv =====
// Lenient UTF-8 byte decoder with drop and fold of the decoded codepoints.
// Emits up to two normalized codepoints per beat. Depends on nkws_pkg.
module nkws_decoder
    import nkws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output cp_pair_t   cps
);

    logic [7:0] lead_reg, lead_next;
    logic [1:0] need_reg, need_next;
    logic [7:0] g0_reg, g1_reg;
    logic       g0_we, g1_we;
    logic [2:0] fb, fg, fl;
    logic [1:0] total;
    logic       idx;
    logic       take_a, take_b;
    cp_t        raw_a, raw_b;

    always_comb
    begin
        fb        = follow_count(text_byte);
        fg        = follow_count(g0_reg);
        fl        = follow_count(lead_reg);
        total     = fl[1:0];
        idx       = 1'((total - need_reg) & 2'd1);
        lead_next = lead_reg;
        need_next = need_reg;
        g0_we     = 1'b0;
        g1_we     = 1'b0;
        take_a    = 1'b0;
        take_b    = 1'b0;
        raw_a     = '0;
        raw_b     = 21'(text_byte);
        if (need_reg == 2'd0) begin
            if (fb == 3'd0) begin
                take_a = 1'b1;
                raw_a  = 21'(text_byte);
            end
            else if (fb != FOLLOW_BAD && !last_byte) begin
                lead_next = text_byte;
                need_next = fb[1:0];
            end
        end
        else if (need_reg == 2'd1) begin
            take_a    = 1'b1;
            need_next = 2'd0;
            case (total)
                2'd1:    raw_a = 21'({lead_reg[4:0], text_byte[5:0]});
                2'd2:    raw_a = 21'({lead_reg[3:0], g0_reg[5:0], text_byte[5:0]});
                default: raw_a = 21'({lead_reg[2:0], g0_reg[5:0], g1_reg[5:0],
                                      text_byte[5:0]});
            endcase
        end
        else if (last_byte) begin
            need_next = 2'd0;
            if (idx) begin
                if (fg == 3'd0) begin
                    take_a = 1'b1;
                    raw_a  = 21'(g0_reg);
                    take_b = (text_byte < 8'h80);
                end
                else if (fg == 3'd1) begin
                    take_a = 1'b1;
                    raw_a  = 21'({g0_reg[4:0], text_byte[5:0]});
                end
                else begin
                    take_a = (text_byte < 8'h80);
                    raw_a  = 21'(text_byte);
                end
            end
            else begin
                take_a = (text_byte < 8'h80);
                raw_a  = 21'(text_byte);
            end
        end
        else begin
            g0_we     = !idx;
            g1_we     = idx;
            need_next = need_reg - 2'd1;
        end
        if (last_byte) begin
            lead_next = '0;
            need_next = '0;
        end
        cps.a_valid = take_a && !is_dropped(raw_a);
        cps.a_cp    = fold_cp(raw_a);
        cps.b_valid = take_b && !is_dropped(raw_b);
        cps.b_cp    = fold_cp(raw_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_reg <= '0;
            need_reg <= '0;
        end
        else if (accept) begin
            lead_reg <= lead_next;
            need_reg <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && g0_we) g0_reg <= text_byte;
        if (accept && g1_we) g1_reg <= text_byte;
    end

    a_need_fits: assert property (@(posedge clk) disable iff (!rst_n)
        need_reg != 2'd0 |-> follow_count(lead_reg) >= {1'b0, need_reg})
        else $error("pending byte count exceeds lead length");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> need_reg == 2'd0 && lead_reg == 8'h00)
        else $error("decoder state not cleared at end of text");

endmodule

// ===== hw/rtl/nkws_cell.sv =====
// One prefix-match cell: holds, per keyword, whether the recent codepoints
// match that keyword's first POS+1 codepoints. Depends on nkws_pkg.
module nkws_cell
    import nkws_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     clear,
    input  cp_pair_t cps,
    input  kw_vec_t  left_state,
    input  kw_vec_t  left_step,
    output kw_vec_t  state,
    output kw_vec_t  step,
    output logic     hit
);

    localparam kw_vec_t MASK = len_mask(POS);

    kw_vec_t state_reg, state_next;
    kw_vec_t eq_a, eq_b, step_b;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++) begin
            eq_a[k] = (cps.a_cp == KW_CP[k][POS]);
            eq_b[k] = (cps.b_cp == KW_CP[k][POS]);
        end
        step       = cps.a_valid ? (left_state & eq_a) : state_reg;
        step_b     = cps.b_valid ? (left_step & eq_b) : step;
        hit        = (cps.a_valid && (|(step & MASK)))
                  || (cps.b_valid && (|(step_b & MASK)));
        state_next = clear ? '0 : step_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule
